// ===== design/bitplane_dma_slot_sequencer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Bitplane DMA slot sequencer assertion macros
// Shared property shorthands for the sequencer checks
// ----------------------------------------------------------------------------
`ifndef BITPLANE_DMA_SLOT_SEQUENCER_CORE_DEFINES_SVH
`define BITPLANE_DMA_SLOT_SEQUENCER_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define BDSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define BDSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bdss_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitplane DMA slot sequencer package
// Shared constants, build parameter type and lookup functions
// ----------------------------------------------------------------------------
package bdss_pkg;

    localparam int LINE_CYCLES_DEF    = 227;
    localparam int MAX_UNIT_SLOTS_DEF = 32;

    localparam logic [15:0] CW_FMODE_BIT = 16'h0010;
    localparam logic [15:0] CW_BPU_MASK  = 16'h7000;

    // register indexes
    localparam logic [1:0] REG_SCROLL_ODD  = 2'd0;
    localparam logic [1:0] REG_SCROLL_EVEN = 2'd1;
    localparam logic [1:0] REG_FETCH_MODE  = 2'd2;
    localparam logic [1:0] REG_CHIP_REV    = 2'd3;

    // resolution codes
    localparam logic [1:0] RES_LO    = 2'd0;
    localparam logic [1:0] RES_HI    = 2'd1;
    localparam logic [1:0] RES_SUPER = 2'd2;

    // draw masks
    localparam logic [2:0] MASK_LO    = 3'b111;
    localparam logic [2:0] MASK_HI    = 3'b011;
    localparam logic [2:0] MASK_SUPER = 3'b001;

    typedef struct packed {
        logic [3:0] bpu;
        logic [1:0] res;
        logic [5:0] unit;
        logic [5:0] start;
        logic [3:0] planes;
    } t_build_cfg;

    function automatic logic [1:0] res_of(input logic [15:0] cw, input logic ecs);
        logic [1:0] r;
        if (cw[6] && ecs) r = RES_SUPER;
        else if (cw[15]) r = RES_HI;
        else r = RES_LO;
        return r;
    endfunction

    function automatic logic [2:0] draw_mask(input logic [1:0] r);
        logic [2:0] m;
        unique case (r)
            RES_LO:  m = MASK_LO;
            RES_HI:  m = MASK_HI;
            default: m = MASK_SUPER;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] unit_lookup(input logic [1:0] fm, input logic [1:0] r);
        logic [5:0] v;
        unique case ({fm, r})
            4'b0000, 4'b0001, 4'b0010: v = 6'd8;
            4'b0100: v = 6'd16;
            4'b0101, 4'b0110: v = 6'd8;
            4'b1000: v = 6'd32;
            4'b1001: v = 6'd16;
            default: v = 6'd8;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] start_lookup(input logic [1:0] fm, input logic [1:0] r);
        logic [5:0] v;
        unique case ({fm, r})
            4'b0000: v = 6'd8;
            4'b0001: v = 6'd4;
            4'b0010: v = 6'd2;
            4'b0100: v = 6'd16;
            4'b0101: v = 6'd8;
            4'b0110: v = 6'd4;
            4'b1000: v = 6'd32;
            4'b1001: v = 6'd16;
            default: v = 6'd8;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] plane_lookup(input logic [1:0] fm, input logic [1:0] r);
        logic [3:0] v;
        unique case ({fm, r})
            4'b0000: v = 4'd8;
            4'b0001: v = 4'd4;
            4'b0010: v = 4'd2;
            4'b0110: v = 4'd4;
            default: v = 4'd8;
        endcase
        return v;
    endfunction

    // fetch order within a unit, by plane group
    function automatic logic [3:0] order_lookup(input logic [3:0] planes, input logic [2:0] c);
        logic [3:0] v;
        if (planes == 4'd2) begin
            v = c[0] ? 4'd1 : 4'd2;
        end else if (planes == 4'd4) begin
            unique case (c[1:0])
                2'd0: v = 4'd4;
                2'd1: v = 4'd2;
                2'd2: v = 4'd3;
                default: v = 4'd1;
            endcase
        end else begin
            unique case (c)
                3'd0: v = 4'd8;
                3'd1: v = 4'd4;
                3'd2: v = 4'd6;
                3'd3: v = 4'd2;
                3'd4: v = 4'd7;
                3'd5: v = 4'd3;
                3'd6: v = 4'd5;
                default: v = 4'd1;
            endcase
        end
        return v;
    endfunction

    function automatic t_build_cfg build_cfg(input logic [15:0] cw, input logic [1:0] rev,
                                             input logic [1:0] fmode);
        t_build_cfg b;
        logic       ecs;
        logic       aga;
        logic [1:0] fm;
        ecs = (rev != 2'd0);
        aga = rev[1];
        b.bpu = {1'b0, cw[14:12]};
        if (aga && ((cw & CW_FMODE_BIT) != 16'h0))
            b.bpu = ((cw & CW_BPU_MASK) != 16'h0) ? 4'd0 : 4'd8;
        b.res = res_of(cw, ecs);
        fm = 2'd0;
        if (aga) begin
            if (fmode == 2'd1 || fmode == 2'd2) fm = 2'd1;
            else if (fmode == 2'd3) fm = 2'd2;
        end
        b.unit   = unit_lookup(fm, b.res);
        b.start  = start_lookup(fm, b.res);
        b.planes = plane_lookup(fm, b.res);
        if (b.res == RES_SUPER && b.planes > 4'd2) b.planes = 4'd2;
        if (b.bpu > b.planes) b.bpu = 4'd0;
        if (!aga) begin
            if (b.res == RES_LO && b.bpu == 4'd7) b.bpu = 4'd4;
            else if (b.res == RES_HI && b.bpu > 4'd4) b.bpu = 4'd0;
            else if (b.res == RES_SUPER && b.bpu > 4'd2) b.bpu = 4'd0;
        end
        return b;
    endfunction

endpackage

// ===== design/bitplane_dma_slot_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// Bitplane DMA slot sequencer core
// Window flag sequencing and per-cycle bitplane slot lookup
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one beat per tick or signal
// change. Output channel (o_out_valid / i_out_stall) carries one beat per tick.
// Registers are to be written by the user over the APB port only while the
// block is idle; the block does not enforce this. A tick goes through the flag
// update and slot table read address, the registered table read and the output
// register; an output stall holds it in the read state. A signal change without
// a control write applies its flags. A control write rebuilds the slot table
// through the shared slot builder at one entry a cycle, all MAX_UNIT_SLOTS
// entries, before the flags are applied.
// o_in_stall is high whenever an item is in work.
// After reset every flag is clear, the unit length is eight and the slot
// table reads as no fetch until the first control write.
// When the receiver stalls, the result beat is held in the output register and
// the next tick waits until that beat has gone.
// ----------------------------------------------------------------------------
`include "bitplane_dma_slot_sequencer_core_defines.svh"

module bitplane_dma_slot_sequencer_core #(
    parameter int LINE_CYCLES    = bdss_pkg::LINE_CYCLES_DEF,
    parameter int MAX_UNIT_SLOTS = bdss_pkg::MAX_UNIT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_hpos,
    input  logic [9:0]  i_signal_flags,
    input  logic [15:0] i_control_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_fetch_plane,
    output logic [1:0]  o_fetch_resolution,
    output logic        o_fetch_adds_modulo,
    output logic        o_draw_odd,
    output logic        o_draw_even,
    output logic        o_dma_running
);

    localparam int AW = $clog2(MAX_UNIT_SLOTS);
    localparam logic [2:0] LINE_LOW = 3'(LINE_CYCLES % 8);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_BUILD = 5'b00010,
        ST_SIG   = 5'b00100,
        ST_TICK  = 5'b01000,
        ST_RD    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [7:0] r_scroll_odd, r_scroll_even;
    logic [1:0] r_fetch_mode, r_chip_rev;
    logic       cfg_wr;
    logic       ecs;

    // sequencer state
    logic       r_vw, n_vw, r_en, n_en, r_ssw, n_ssw, r_stw, n_stw;
    logic       r_dst, n_dst, r_dsp, n_dsp, r_run, n_run, r_last, n_last;
    logic       r_sreq, n_sreq;
    logic [3:0] r_uc, n_uc;
    logic [15:0] r_cw;
    logic [5:0] r_unit_len;
    logic [1:0] r_unit_res;
    logic       r_tbl_valid;

    // latched beat
    logic [7:0] r_hpos;
    logic [9:0] r_sig;

    // pending tick result
    logic       r_p_fetch, n_p_fetch, r_p_row, n_p_row;
    logic       r_p_odd, n_p_odd, r_p_even, n_p_even;
    logic [AW-1:0] r_raddr, n_raddr;

    // output register
    logic       r_ovalid;
    logic [3:0] r_o_plane;
    logic [1:0] r_o_res;
    logic       r_o_mod, r_o_odd, r_o_even, r_o_run;

    logic       in_acc;
    logic       out_load;
    logic       bld_start;
    logic       bld_busy, bld_done, bld_we;
    logic [AW-1:0] bld_addr;
    logic [9:0] bld_data, ram_rdata;
    bdss_pkg::t_build_cfg new_cfg;

    logic [4:0] counter;
    logic [3:0] cmask;
    logic [2:0] dmask, jj;
    logic       on;
    logic [4:0] entry;

    assign ecs     = (r_chip_rev != 2'd0);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign new_cfg = bdss_pkg::build_cfg(i_control_value, r_chip_rev, r_fetch_mode);
    assign bld_start = in_acc && i_operation && i_signal_flags[8];

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_odd  <= '0;
            r_scroll_even <= '0;
            r_fetch_mode  <= '0;
            r_chip_rev    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                bdss_pkg::REG_SCROLL_ODD:  r_scroll_odd  <= pwdata[7:0];
                bdss_pkg::REG_SCROLL_EVEN: r_scroll_even <= pwdata[7:0];
                bdss_pkg::REG_FETCH_MODE:  r_fetch_mode  <= pwdata[1:0];
                default:                   r_chip_rev    <= pwdata[1:0];
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (paddr[3:2])
            bdss_pkg::REG_SCROLL_ODD:  prdata = {24'd0, r_scroll_odd};
            bdss_pkg::REG_SCROLL_EVEN: prdata = {24'd0, r_scroll_even};
            bdss_pkg::REG_FETCH_MODE:  prdata = {30'd0, r_fetch_mode};
            default:                   prdata = {30'd0, r_chip_rev};
        endcase
    end

    // shared slot builder and table
    bdss_slot_builder #(
        .MAX_UNIT_SLOTS (MAX_UNIT_SLOTS)
    ) u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bld_start),
        .i_cfg   (new_cfg),
        .o_busy  (bld_busy),
        .o_done  (bld_done),
        .o_we    (bld_we),
        .o_addr  (bld_addr),
        .o_data  (bld_data)
    );

    // read address is presented in the tick cycle and held while the result waits
    bdss_ram #(
        .WIDTH (10),
        .DEPTH (MAX_UNIT_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (bld_we),
        .i_waddr (bld_addr),
        .i_wdata (bld_data),
        .i_raddr (n_raddr),
        .o_rdata (ram_rdata)
    );

    // tick arithmetic
    assign counter = {r_uc, r_hpos[0]};
    assign cmask   = 4'((r_unit_len >> 1) - 6'd1);
    assign dmask   = bdss_pkg::draw_mask(bdss_pkg::res_of(r_cw, ecs));
    assign jj      = (r_hpos != 8'd0) ? r_hpos[2:0] : LINE_LOW;
    assign out_load = (r_state == ST_RD) && (!r_ovalid || !i_out_stall);

    // flag sequencing and control
    always_comb begin
        n_state = r_state;
        n_vw = r_vw;  n_en = r_en;  n_ssw = r_ssw; n_stw = r_stw;
        n_dst = r_dst; n_dsp = r_dsp; n_run = r_run; n_last = r_last;
        n_sreq = r_sreq; n_uc = r_uc;
        n_p_fetch = r_p_fetch; n_p_row = r_p_row;
        n_p_odd = r_p_odd; n_p_even = r_p_even; n_raddr = r_raddr;
        on = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!i_operation) n_state = ST_TICK;
                    else if (i_signal_flags[8]) n_state = ST_BUILD;
                    else n_state = ST_SIG;
                end
            end
            ST_BUILD: begin
                if (bld_done) n_state = ST_SIG;
            end
            ST_SIG: begin
                n_state = ST_IDLE;
                if (!ecs) begin
                    // original chipset rules
                    if (r_sig[5:4] == 2'b10) begin
                        n_en = 1'b0; n_run = 1'b0; n_uc = '0;
                    end else if (r_sig[5:4] == 2'b01) n_en = 1'b1;
                    if (r_sig[7:6] == 2'b01) n_vw = 1'b1;
                    else if (r_sig[7:6] == 2'b10) begin
                        n_vw = 1'b0; n_run = 1'b0; n_uc = '0;
                    end
                    if (r_sig[1:0] == 2'b01) n_ssw = 1'b1;
                    else if (r_sig[1:0] == 2'b10) begin
                        n_stw = n_stw | n_run; n_sreq = n_sreq | n_run;
                    end
                    if (r_sig[3:2] == 2'b11) begin
                        if (n_run) begin
                            n_dst = 1'b0; n_dsp = 1'b1; n_sreq = 1'b1;
                        end else begin
                            n_dst = n_dst | n_ssw;
                            n_run = n_ssw & n_vw & n_en;
                        end
                    end else if (r_sig[3:2] == 2'b01) begin
                        n_dst = n_dst | (n_ssw & n_en);
                        n_run = (n_run | n_ssw) & n_vw & n_en;
                    end else if (r_sig[3:2] == 2'b10) begin
                        if (n_run) n_dst = 1'b0;
                        n_dsp = n_dsp | n_run;
                        n_sreq = n_sreq | n_run;
                    end
                    if (r_sig[9]) begin
                        n_stw = 1'b0; n_sreq = 1'b0;
                    end
                end else begin
                    // enhanced chipset rules
                    if (r_sig[7:6] == 2'b01) n_vw = 1'b1;
                    else if (r_sig[7:6] == 2'b10) begin
                        n_vw = 1'b0; n_run = 1'b0; n_uc = '0;
                    end
                    if (r_sig[1:0] == 2'b01) begin
                        n_ssw = 1'b1;
                        n_run = n_run | (n_dst & !r_sig[3]);
                    end else if (r_sig[1:0] == 2'b10) begin
                        n_stw = 1'b1;
                        n_sreq = n_sreq | n_run;
                    end
                    on = (n_run | n_ssw) & n_vw & n_en;
                    unique case (r_sig[3:0])
                        4'hD: begin
                            n_dst = 1'b1; n_run = on;
                        end
                        4'hE: begin
                            n_dsp = n_dsp | n_run; n_sreq = n_sreq | n_run; n_dst = 1'b1;
                        end
                        4'hC: begin
                            n_dsp = n_dsp | n_run; n_sreq = n_sreq | n_run;
                            n_dst = n_vw; n_run = on;
                        end
                        4'h4, 4'h5, 4'h6: begin
                            n_dst = 1'b1; n_run = on;
                        end
                        4'h8, 4'h9, 4'hA: begin
                            n_dst = 1'b0; n_dsp = n_dsp | n_run; n_sreq = n_sreq | n_run;
                        end
                        default: ;
                    endcase
                    if (r_sig[5:4] == 2'b10) begin
                        n_en = 1'b0; n_run = 1'b0; n_uc = '0;
                    end else if (r_sig[5:4] == 2'b01) begin
                        n_en = 1'b1;
                        n_run = (n_run | n_ssw) & n_vw & n_dst;
                    end
                    if (r_sig[9]) begin
                        n_stw = 1'b0; n_ssw = 1'b0; n_dsp = 1'b0;
                        if (r_unit_len > 6'd8) begin
                            n_run = 1'b0; n_last = 1'b0; n_sreq = 1'b0; n_uc = '0;
                        end
                    end
                end
            end
            ST_TICK: begin
                n_state = ST_RD;
                if (counter == 5'd0) begin
                    if (n_last) begin
                        n_run = 1'b0; n_last = 1'b0; n_dsp = 1'b0;
                        if (!ecs) n_ssw = 1'b0;
                    end
                    if (n_sreq) begin
                        n_sreq = 1'b0; n_last = 1'b1;
                    end
                end
                n_p_fetch = 1'b0;
                if (n_run) begin
                    n_p_fetch = (6'(counter) < 6'(MAX_UNIT_SLOTS));
                    if (r_hpos[0]) n_uc = (r_uc + 4'd1) & cmask;
                end else begin
                    n_uc = '0;
                end
                n_p_row  = n_last;
                n_raddr  = AW'(counter);
                n_p_odd  = ((jj & dmask) == (r_scroll_odd[2:0] & dmask));
                n_p_even = ((jj & dmask) == (r_scroll_even[2:0] & dmask));
            end
            default: begin
                // result read
                if (!r_ovalid || !i_out_stall) n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vw <= 1'b0; r_en <= 1'b0; r_ssw <= 1'b0; r_stw <= 1'b0;
            r_dst <= 1'b0; r_dsp <= 1'b0; r_run <= 1'b0; r_last <= 1'b0;
            r_sreq <= 1'b0; r_uc <= '0;
            r_cw <= '0;
            r_unit_len <= 6'd8;
            r_unit_res <= bdss_pkg::RES_LO;
            r_tbl_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vw <= n_vw; r_en <= n_en; r_ssw <= n_ssw; r_stw <= n_stw;
            r_dst <= n_dst; r_dsp <= n_dsp; r_run <= n_run; r_last <= n_last;
            r_sreq <= n_sreq; r_uc <= n_uc;
            if (bld_start) begin
                r_cw        <= i_control_value;
                r_unit_len  <= new_cfg.unit;
                r_unit_res  <= new_cfg.res;
                r_tbl_valid <= 1'b1;
            end
        end
    end

    // beat and pending result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hpos <= i_hpos;
            r_sig  <= i_signal_flags;
        end
        r_p_fetch <= n_p_fetch;
        r_p_row   <= n_p_row;
        r_p_odd   <= n_p_odd;
        r_p_even  <= n_p_even;
        r_raddr   <= n_raddr;
    end

    // slot entry from the table read
    assign entry = (r_p_fetch && r_tbl_valid) ?
                   (r_p_row ? ram_rdata[9:5] : ram_rdata[4:0]) : 5'd0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_plane <= entry[3:0];
            r_o_res   <= (entry[3:0] != 4'd0) ? r_unit_res : bdss_pkg::RES_LO;
            r_o_mod   <= entry[4];
            r_o_odd   <= r_p_odd;
            r_o_even  <= r_p_even;
            r_o_run   <= r_run;
        end
    end

    assign o_out_valid         = r_ovalid;
    assign o_fetch_plane       = r_o_plane;
    assign o_fetch_resolution  = r_o_res;
    assign o_fetch_adds_modulo = r_o_mod;
    assign o_draw_odd          = r_o_odd;
    assign o_draw_even         = r_o_even;
    assign o_dma_running       = r_o_run;

    // checks
    `BDSS_ASSERT_NOW(a_fetch_needs_run, o_out_valid && (o_fetch_plane != 4'd0), o_dma_running, "fetch reported while not running")
    `BDSS_ASSERT_NOW(a_idle_slot_quiet, o_out_valid && (o_fetch_plane == 4'd0), !o_fetch_adds_modulo && (o_fetch_resolution == 2'd0), "no-fetch slot carries fetch detail")
    `BDSS_ASSERT_NOW(a_build_blocks_input, bld_busy, o_in_stall, "input taken during table build")
    `BDSS_ASSERT_NEXT(a_tick_reaches_read, r_state == ST_TICK, r_state == ST_RD, "tick did not move to table read")

endmodule

// ===== design/bdss_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bdss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bdss_slot_builder.sv =====
// ----------------------------------------------------------------------------
// Slot table builder
// Sweeps the slot table one entry a cycle and writes both unit variants
// ----------------------------------------------------------------------------
module bdss_slot_builder #(
    parameter int MAX_UNIT_SLOTS = bdss_pkg::MAX_UNIT_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  bdss_pkg::t_build_cfg              i_cfg,
    output logic                              o_busy,
    output logic                              o_done,
    output logic                              o_we,
    output logic [$clog2(MAX_UNIT_SLOTS)-1:0] o_addr,
    output logic [9:0]                        o_data
);

    localparam int AW = $clog2(MAX_UNIT_SLOTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_UNIT_SLOTS - 1);

    logic                 r_busy, n_busy;
    logic [AW-1:0]        r_idx, n_idx;
    bdss_pkg::t_build_cfg r_cfg;
    logic [5:0]           idx_x;
    logic [5:0]           c;
    logic [3:0]           p;
    logic [4:0]           row0, row1;

    // entry for the current index
    always_comb begin
        idx_x = 6'(r_idx);
        c     = idx_x & (r_cfg.start - 6'd1);
        p     = bdss_pkg::order_lookup(r_cfg.planes, c[2:0]);
        row0  = 5'd0;
        row1  = 5'd0;
        if (idx_x < r_cfg.unit && c < 6'(r_cfg.planes) && r_cfg.bpu >= p) begin
            row0 = {1'b0, p};
            row1 = {(idx_x >= (r_cfg.unit - r_cfg.start)), p};
        end
    end

    // sweep control
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (r_busy) begin
            if (r_idx == LAST_IDX) n_busy = 1'b0;
            else n_idx = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    // build parameters held for the sweep
    always_ff @(posedge i_clk) begin
        if (i_start) r_cfg <= i_cfg;
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_idx == LAST_IDX);
    assign o_we   = r_busy;
    assign o_addr = r_idx;
    assign o_data = {row1, row0};

endmodule
